// File: hdl/sbh_pkg.sv
// shared constants and types for the string bucket hash block
`default_nettype none
package sbh_pkg;

	// running hash width, 16 to 64
	localparam int HASH_WIDTH = 32;
	// bucket count register width
	localparam int LEN_WIDTH = 31;
	// byte width of one string character
	localparam int CHAR_WIDTH = 8;
	// apb data and address widths
	localparam int APB_DATA_WIDTH = 32;
	localparam int APB_ADDR_WIDTH = 3;
	// divider step counter width
	localparam int CNT_WIDTH = $clog2(HASH_WIDTH);

	// hash bias, the character 'a'
	localparam logic [CHAR_WIDTH-1:0] HASH_BIAS = 8'd97;
	// reset value of the bucket count
	localparam logic [LEN_WIDTH-1:0] LEN_RESET = LEN_WIDTH'(1);

	// register word index
	localparam logic [APB_ADDR_WIDTH-3:0] REG_TABLE_LENGTH = '0;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

endpackage
`default_nettype wire

// File: hdl/string_bucket_hash.sv
// string bucket hash: polynomial string hash reduced modulo a bucket count
//
// Input channel (char_byte, in_valid, in_ready) carries one string byte per
// beat. A nonzero byte updates the running hash to hash*13 + byte - 'a' in the
// cycle it is accepted, so string bytes stream at one per cycle. A zero byte
// ends the string: the block then reduces the hash modulo table_length with a
// restoring divider that retires one quotient bit per cycle, and drops
// in_ready until the result is in the output register. The next beat is
// taken right after the result is loaded, while it waits to be taken.
// Output channel (bucket_index, out_valid, out_ready) holds the result in a
// register until the receiver takes it. If the receiver stalls and a second
// string finishes, the block holds its result in the divider and keeps
// in_ready low until the output register frees up.
// table_length lives at APB byte address 0 (reset value 1); a table_length
// of zero gives bucket_index 0. Configure only while the block is idle.
// Reset clears the running hash, the sequencer and the output valid flag.
`default_nettype none
module string_bucket_hash (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// apb configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [sbh_pkg::APB_ADDR_WIDTH-1:0]  paddr,
	input  wire logic [sbh_pkg::APB_DATA_WIDTH-1:0]  pwdata,
	output logic      [sbh_pkg::APB_DATA_WIDTH-1:0]  prdata,
	output logic                                     pready,
	// input channel
	input  wire logic [sbh_pkg::CHAR_WIDTH-1:0]      char_byte,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	// output channel
	output logic      [sbh_pkg::LEN_WIDTH-1:0]       bucket_index,
	output logic                                     out_valid,
	input  wire logic                                out_ready
);

	localparam int HW = sbh_pkg::HASH_WIDTH;
	localparam int LW = sbh_pkg::LEN_WIDTH;

	sbh_pkg::state_t               state_q;
	logic [LW-1:0]                 table_length_q;
	logic [HW-1:0]                 hash_q;
	logic [HW-1:0]                 dvd_q;
	logic [LW-1:0]                 rem_q;
	logic [sbh_pkg::CNT_WIDTH-1:0] cnt_q;
	logic [LW-1:0]                 bucket_q;
	logic                          out_valid_q;

	logic                          in_beat;
	logic                          cfg_wr;
	logic                          out_free;
	logic [HW-1:0]                 hash_next;
	logic [LW:0]                   trial;
	logic [LW+1:0]                 diff;
	logic [LW-1:0]                 rem_next;

	// handshakes
	assign in_beat  = in_valid && in_ready;
	assign in_ready = (state_q == sbh_pkg::ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// apb read side
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[sbh_pkg::APB_ADDR_WIDTH-1:2] == sbh_pkg::REG_TABLE_LENGTH) begin
			prdata = sbh_pkg::APB_DATA_WIDTH'(table_length_q);
		end
	end

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= sbh_pkg::LEN_RESET;
		end else if (cfg_wr &&
				paddr[sbh_pkg::APB_ADDR_WIDTH-1:2] == sbh_pkg::REG_TABLE_LENGTH) begin
			table_length_q <= pwdata[LW-1:0];
		end
	end

	// hash update: h*13 + byte - 'a', as shifts and adds
	assign hash_next = hash_q + (hash_q << 2) + (hash_q << 3)
		+ HW'(char_byte) - HW'(sbh_pkg::HASH_BIAS);

	// divider step: shift in next dividend bit, subtract if it fits
	assign trial    = {rem_q, dvd_q[HW-1]};
	assign diff     = {1'b0, trial} - {2'b00, table_length_q};
	assign rem_next = diff[LW+1] ? trial[LW-1:0] : diff[LW-1:0];

	// sequencer and running hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbh_pkg::ST_IDLE;
			hash_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				sbh_pkg::ST_IDLE: begin
					if (in_beat) begin
						if (char_byte != '0) begin
							hash_q <= hash_next;
						end else begin
							hash_q  <= '0;
							cnt_q   <= sbh_pkg::CNT_WIDTH'(HW - 1);
							state_q <= sbh_pkg::ST_DIV;
						end
					end
				end
				sbh_pkg::ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= sbh_pkg::ST_FIN;
					end
				end
				sbh_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= sbh_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= sbh_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (in_beat && char_byte == '0) begin
			dvd_q <= hash_q;
			rem_q <= '0;
		end else if (state_q == sbh_pkg::ST_DIV) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == sbh_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sbh_pkg::ST_FIN && out_free) begin
			bucket_q <= (table_length_q == '0) ? '0 : rem_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;

endmodule
`default_nettype wire

// File: hdl/sbh_checker.sv
// port-level checker for the string bucket hash block, with its bind
`default_nettype none
module sbh_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                pready,
	input wire logic [sbh_pkg::CHAR_WIDTH-1:0]      char_byte,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic [sbh_pkg::LEN_WIDTH-1:0]       bucket_index,
	input wire logic                                out_valid,
	input wire logic                                out_ready
);

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bucket_index))
		else $error("stalled result dropped or changed");

	// a terminating beat makes the block busy for the reduction
	a_term_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && char_byte == '0 |=> !in_ready)
		else $error("block ready right after a string terminator");

	// a new result only appears after a busy cycle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a reduction");

	// the configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind string_bucket_hash sbh_checker u_sbh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.char_byte    (char_byte),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.bucket_index (bucket_index),
	.out_valid    (out_valid),
	.out_ready    (out_ready)
);
`default_nettype wire
